// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/thm_pkg.sv -----
`timescale 1ns / 1ps

package thm_pkg;

	// Converter and channel setup.
	localparam int unsigned ADC_BITS = 12;
	localparam int unsigned ADC_FULL = 1 << ADC_BITS;
	localparam int unsigned CHANNELS = 8;
	localparam int unsigned FIRST_GROUP = 2;

	// Field widths.
	localparam int unsigned CH_W = 3;
	localparam int unsigned CODE_W = 12;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned BETA_W = 14;
	localparam int unsigned OHM_W = 20;
	localparam int unsigned CFG_DATA_W = 20;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_BETA_FIRST = 2'd0,
		CFG_BETA_OTHER = 2'd1,
		CFG_R0         = 2'd2,
		CFG_SERIES     = 2'd3
	} cfg_index_t;

	localparam logic [BETA_W-1:0] BETA_FIRST_RST = BETA_W'(3940);
	localparam logic [BETA_W-1:0] BETA_OTHER_RST = BETA_W'(3892);
	localparam logic [OHM_W-1:0] R0_RST = OHM_W'(10000);
	localparam logic [OHM_W-1:0] SERIES_RST = OHM_W'(19000);

	// Fixed point: logarithms carry 30 fraction bits.
	localparam int unsigned FRAC_W = 30;
	localparam logic [FRAC_W-1:0] LN2_Q = FRAC_W'(744261118);

	// Logarithm lane.
	localparam int unsigned LOG_W = 20;
	localparam int unsigned LOG_INT_W = 5;
	localparam int unsigned LOG_M_W = FRAC_W + 1;
	localparam int unsigned LOG_R_W = LOG_INT_W + FRAC_W;
	localparam int unsigned LOG_LO_W = 32;
	localparam int unsigned LOG_HI_W = LOG_R_W - LOG_LO_W;
	localparam int unsigned LN_W = LOG_R_W;
	localparam int unsigned LN_LAT = 2 + FRAC_W + 2;

	// Temperature constants in hundredths.
	localparam int unsigned CENTI = 100;
	localparam longint unsigned T0_CENTI = 29815;
	localparam int ZERO_C_CENTI = 27315;
	localparam int TEMP_MAX = 32767;
	localparam int TK_MAX = TEMP_MAX + ZERO_C_CENTI;
	localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = TEMP_W'(-ZERO_C_CENTI);
	localparam logic signed [TEMP_W-1:0] TEMP_CEIL = TEMP_W'(TEMP_MAX);

	// beta*100*2^30/29815 is split as beta*CD_A + (beta*CD_B + half)/29815.
	// The small term is divided by multiplying with a rounded-up reciprocal,
	// exact for every dividend below 2^29.
	localparam longint unsigned KNUM = longint'(CENTI) << FRAC_W;
	localparam longint unsigned CD_A = KNUM / T0_CENTI;
	localparam longint unsigned CD_B = KNUM % T0_CENTI;
	localparam int unsigned T0_W = 15;
	localparam int unsigned CT_W = BETA_W + T0_W;
	localparam int unsigned CQ_W = BETA_W;
	localparam int unsigned CD_SH = CT_W + T0_W;
	localparam int unsigned CD_M_W = 30;
	localparam longint unsigned CD_M = ((64'd1 << CD_SH) + T0_CENTI - 1) / T0_CENTI;
	localparam int unsigned KB_W = 36;
	localparam int unsigned KBD_LEN = LN_LAT - 2;

	// Back end widths.
	localparam int unsigned SPOS_W = 37;
	localparam int unsigned SNEG_W = 36;
	localparam int unsigned X_W = SPOS_W;
	localparam int unsigned BETA100_W = 21;
	localparam int unsigned NUM_W = 52;
	localparam int unsigned Q_W = 16;
	localparam int unsigned REM_W = X_W + Q_W;
	localparam int unsigned DIV_LAT = 4 + Q_W + 1;

	// Whole pipeline from the input register to the back end result.
	localparam int unsigned PIPE_LAT = 1 + LN_LAT + DIV_LAT;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     fault;
	} thm_res_t;

endpackage

// ----- hdl/thm_ifs.sv -----
`timescale 1ns / 1ps

// Sample channel: one ADC reading per request.
interface thm_sample_if;
	logic                        valid;
	logic                        ready;
	logic [thm_pkg::CH_W-1:0]    channel;
	logic [thm_pkg::CODE_W-1:0]  adc_code;

	modport source (output valid, output channel, output adc_code, input ready);
	modport sink (input valid, input channel, input adc_code, output ready);
endinterface

// Result channel: one temperature per request.
interface thm_result_if;
	logic                               valid;
	logic                               ready;
	logic [thm_pkg::CH_W-1:0]           channel_out;
	logic signed [thm_pkg::TEMP_W-1:0]  temp_centi_c;
	logic                               fault;

	modport source (output valid, output channel_out, output temp_centi_c, output fault,
		input ready);
	modport sink (input valid, input channel_out, input temp_centi_c, input fault,
		output ready);
endinterface

// Register write channel.
interface thm_cfg_if;
	logic                            valid;
	logic                            ready;
	thm_pkg::cfg_index_t             index;
	logic [thm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/thm_log_lane.sv -----
`timescale 1ns / 1ps

// Natural logarithm of an unsigned integer in Q30, one squaring per stage.
module thm_log_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [thm_pkg::LOG_W-1:0]   n,
	output logic [thm_pkg::LN_W-1:0]    ln
);

	localparam int unsigned PROD_W = thm_pkg::LOG_R_W + thm_pkg::FRAC_W;
	localparam int unsigned SQ_W = 2 * thm_pkg::LOG_M_W;

	logic [thm_pkg::LOG_W-1:0]        n_s1;
	logic [thm_pkg::LOG_INT_W-1:0]    msb_c;
	logic [thm_pkg::LOG_INT_W-1:0]    msb_s1;
	logic [thm_pkg::LOG_M_W-1:0]      m_c;
	logic [thm_pkg::LOG_M_W-1:0]      m_s [thm_pkg::FRAC_W+1];
	logic [thm_pkg::LOG_R_W-1:0]      r_s [thm_pkg::FRAC_W+1];
	logic [SQ_W-1:0]                  sq_c [thm_pkg::FRAC_W];
	logic [thm_pkg::LOG_M_W:0]        t_c [thm_pkg::FRAC_W];
	logic [thm_pkg::LOG_M_W-1:0]      m_nx [thm_pkg::FRAC_W];
	logic [thm_pkg::LOG_R_W-1:0]      r_nx [thm_pkg::FRAC_W];
	logic [thm_pkg::LOG_LO_W+thm_pkg::FRAC_W-1:0] plo_s;
	logic [thm_pkg::LOG_HI_W+thm_pkg::FRAC_W-1:0] phi_s;
	logic [PROD_W-1:0]                prod_c;
	logic [thm_pkg::LN_W-1:0]         ln_s;

	// Position of the leading one; the last set bit wins.
	always_comb begin
		msb_c = '0;
		for (int i = 0; i < thm_pkg::LOG_W; i++) begin
			if (n[i]) begin
				msb_c = thm_pkg::LOG_INT_W'(i);
			end
		end
	end

	// Normalize the mantissa to [1, 2) in Q30.
	assign m_c = thm_pkg::LOG_M_W'(n_s1) << (thm_pkg::LOG_INT_W'(thm_pkg::FRAC_W) - msb_s1);

	// Each squaring yields one fraction bit of log2, msb first.
	always_comb begin
		for (int k = 0; k < thm_pkg::FRAC_W; k++) begin
			sq_c[k] = SQ_W'(m_s[k]) * SQ_W'(m_s[k]);
			t_c[k] = sq_c[k][thm_pkg::FRAC_W +: thm_pkg::LOG_M_W+1];
			if (t_c[k][thm_pkg::LOG_M_W]) begin
				m_nx[k] = t_c[k][thm_pkg::LOG_M_W:1];
				r_nx[k] = r_s[k] | (thm_pkg::LOG_R_W'(1) << (thm_pkg::FRAC_W - 1 - k));
			end else begin
				m_nx[k] = t_c[k][thm_pkg::LOG_M_W-1:0];
				r_nx[k] = r_s[k];
			end
		end
	end

	// log2 times ln2, rebuilt from the two partial products.
	assign prod_c = (PROD_W'(phi_s) << thm_pkg::LOG_LO_W) + PROD_W'(plo_s);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n;
			msb_s1 <= msb_c;
			m_s[0] <= m_c;
			r_s[0] <= {msb_s1, {thm_pkg::FRAC_W{1'b0}}};
			for (int k = 0; k < thm_pkg::FRAC_W; k++) begin
				m_s[k+1] <= m_nx[k];
				r_s[k+1] <= r_nx[k];
			end
			plo_s <= (thm_pkg::LOG_LO_W+thm_pkg::FRAC_W)'(
				r_s[thm_pkg::FRAC_W][thm_pkg::LOG_LO_W-1:0])
				* (thm_pkg::LOG_LO_W+thm_pkg::FRAC_W)'(thm_pkg::LN2_Q);
			phi_s <= (thm_pkg::LOG_HI_W+thm_pkg::FRAC_W)'(
				r_s[thm_pkg::FRAC_W][thm_pkg::LOG_R_W-1:thm_pkg::LOG_LO_W])
				* (thm_pkg::LOG_HI_W+thm_pkg::FRAC_W)'(thm_pkg::LN2_Q);
			ln_s <= prod_c[thm_pkg::FRAC_W +: thm_pkg::LN_W];
		end
	end

	assign ln = ln_s;

endmodule

// ----- hdl/thm_cdiv.sv -----
`timescale 1ns / 1ps

// Rounded beta*100*2^30/29815, delayed to line up with the logarithm lanes.
module thm_cdiv (
	input  logic                        clk,
	input  logic                        en,
	input  logic [thm_pkg::BETA_W-1:0]  beta,
	output logic [thm_pkg::KB_W-1:0]    kb,
	output logic [thm_pkg::BETA_W-1:0]  beta_out
);

	localparam int unsigned PM_W = thm_pkg::CT_W + thm_pkg::CD_M_W;

	logic [thm_pkg::KB_W-1:0]    p_s1;
	logic [thm_pkg::CT_W-1:0]    y_s1;
	logic [thm_pkg::BETA_W-1:0]  bt_s1;
	logic [thm_pkg::KB_W-1:0]    p_s2;
	logic [PM_W-1:0]             pm_s2;
	logic [thm_pkg::BETA_W-1:0]  bt_s2;
	logic [thm_pkg::CQ_W-1:0]    q_c;
	logic [thm_pkg::KB_W-1:0]    kb_d [thm_pkg::KBD_LEN];
	logic [thm_pkg::BETA_W-1:0]  bt_d [thm_pkg::KBD_LEN];

	// Quotient of the small remainder term by the constant.
	assign q_c = pm_s2[thm_pkg::CD_SH +: thm_pkg::CQ_W];

	always_ff @(posedge clk) begin
		if (en) begin
			// Whole part and remainder part of the quotient.
			p_s1 <= thm_pkg::KB_W'(beta) * thm_pkg::KB_W'(thm_pkg::CD_A);
			y_s1 <= thm_pkg::CT_W'(beta) * thm_pkg::CT_W'(thm_pkg::CD_B)
				+ thm_pkg::CT_W'(thm_pkg::T0_CENTI / 2);
			bt_s1 <= beta;

			// Reciprocal multiplication of the remainder term.
			pm_s2 <= PM_W'(y_s1) * PM_W'(thm_pkg::CD_M);
			p_s2 <= p_s1;
			bt_s2 <= bt_s1;

			kb_d[0] <= p_s2 + thm_pkg::KB_W'(q_c);
			bt_d[0] <= bt_s2;
			for (int j = 1; j < thm_pkg::KBD_LEN; j++) begin
				kb_d[j] <= kb_d[j-1];
				bt_d[j] <= bt_d[j-1];
			end
		end
	end

	assign kb = kb_d[thm_pkg::KBD_LEN-1];
	assign beta_out = bt_d[thm_pkg::KBD_LEN-1];

endmodule

// ----- hdl/thm_div.sv -----
`timescale 1ns / 1ps

// Sums the logarithms and divides beta*100*2^30 by the result, with saturation.
module thm_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [thm_pkg::LN_W-1:0]    ln_code,
	input  logic [thm_pkg::LN_W-1:0]    ln_rest,
	input  logic [thm_pkg::LN_W-1:0]    ln_ser,
	input  logic [thm_pkg::LN_W-1:0]    ln_r0,
	input  logic [thm_pkg::KB_W-1:0]    kb,
	input  logic [thm_pkg::BETA_W-1:0]  beta,
	output thm_pkg::thm_res_t           res
);

	logic [thm_pkg::SPOS_W-1:0]   spos_s1;
	logic [thm_pkg::SNEG_W-1:0]   sneg_s1;
	logic [thm_pkg::BETA_W-1:0]   beta_s1;
	logic [thm_pkg::X_W-1:0]      xd_s2;
	logic                         nonpos_s2;
	logic [thm_pkg::BETA_W-1:0]   beta_s2;
	logic [thm_pkg::NUM_W-1:0]    num_c;
	logic [thm_pkg::NUM_W-1:0]    nn_s3;
	logic [thm_pkg::X_W-1:0]      xd_s3;
	logic                         nonpos_s3;
	logic [thm_pkg::REM_W-1:0]    rem_s [thm_pkg::Q_W+1];
	logic [thm_pkg::Q_W-1:0]      q_s [thm_pkg::Q_W+1];
	logic [thm_pkg::X_W-1:0]      xd_s [thm_pkg::Q_W+1];
	logic                         sat_s [thm_pkg::Q_W+1];
	logic [thm_pkg::REM_W-1:0]    dsh_c [thm_pkg::Q_W];
	logic [thm_pkg::REM_W-1:0]    rem_nx [thm_pkg::Q_W];
	logic [thm_pkg::Q_W-1:0]      q_nx [thm_pkg::Q_W];
	thm_pkg::thm_res_t            res_s21;

	// Numerator beta*100 in Q30.
	assign num_c = thm_pkg::NUM_W'(thm_pkg::BETA100_W'(beta_s2)
		* thm_pkg::BETA100_W'(thm_pkg::CENTI)) << thm_pkg::FRAC_W;

	// One quotient bit per stage, msb first.
	always_comb begin
		for (int k = 0; k < thm_pkg::Q_W; k++) begin
			dsh_c[k] = thm_pkg::REM_W'(xd_s[k]) << (thm_pkg::Q_W - 1 - k);
			if (rem_s[k] >= dsh_c[k]) begin
				rem_nx[k] = rem_s[k] - dsh_c[k];
				q_nx[k] = q_s[k] | (thm_pkg::Q_W'(1) << (thm_pkg::Q_W - 1 - k));
			end else begin
				rem_nx[k] = rem_s[k];
				q_nx[k] = q_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Positive and negative halves of the denominator.
			spos_s1 <= thm_pkg::SPOS_W'(ln_code) + thm_pkg::SPOS_W'(ln_ser)
				+ thm_pkg::SPOS_W'(kb);
			sneg_s1 <= thm_pkg::SNEG_W'(ln_rest) + thm_pkg::SNEG_W'(ln_r0);
			beta_s1 <= beta;

			xd_s2 <= spos_s1 - thm_pkg::SPOS_W'(sneg_s1);
			nonpos_s2 <= (spos_s1 <= thm_pkg::SPOS_W'(sneg_s1));
			beta_s2 <= beta_s1;

			// Add half the divisor so the quotient rounds to nearest.
			nn_s3 <= num_c + thm_pkg::NUM_W'(xd_s2 >> 1);
			xd_s3 <= xd_s2;
			nonpos_s3 <= nonpos_s2;

			// A quotient of 2^16 or more saturates anyway.
			rem_s[0] <= thm_pkg::REM_W'(nn_s3);
			q_s[0] <= '0;
			xd_s[0] <= xd_s3;
			sat_s[0] <= nonpos_s3
				|| (thm_pkg::REM_W'(nn_s3) >= (thm_pkg::REM_W'(xd_s3) << thm_pkg::Q_W));

			for (int k = 0; k < thm_pkg::Q_W; k++) begin
				rem_s[k+1] <= rem_nx[k];
				q_s[k+1] <= q_nx[k];
				xd_s[k+1] <= xd_s[k];
				sat_s[k+1] <= sat_s[k];
			end

			// Convert centikelvin to centidegrees, clamping at the top.
			if (sat_s[thm_pkg::Q_W]
				|| (q_s[thm_pkg::Q_W] > thm_pkg::Q_W'(thm_pkg::TK_MAX))) begin
				res_s21.temp <= thm_pkg::TEMP_CEIL;
				res_s21.fault <= 1'b1;
			end else begin
				res_s21.temp <= thm_pkg::TEMP_W'(q_s[thm_pkg::Q_W])
					- thm_pkg::TEMP_W'(thm_pkg::ZERO_C_CENTI);
				res_s21.fault <= 1'b0;
			end
		end
	end

	assign res = res_s21;

endmodule

// ----- hdl/thermistor_adc_to_temperature_core.sv -----
`timescale 1ns / 1ps
// Channel   Role    Payload                                  Transfer
// sample    sink    channel, adc_code                        valid && ready
// result    source  channel_out, temp_centi_c, fault         valid && ready
// cfg       sink    index, data                              valid && ready (ready held high)
//
// One request is accepted per cycle while the skid register is empty; a result passes
// through the 30 squaring stages of the log lanes and the 16-stage restoring divider.
// arst_n clears the pipeline valid bits and the output and skid valid flags, and loads
// the register reset values. A stalled result sits in the output register; the next
// one goes to a skid register, and only a full skid register holds the pipeline.
`include "assert_macros.svh"

module thermistor_adc_to_temperature_core (
	input  logic          clk,
	input  logic          arst_n,
	thm_sample_if.sink    sample,
	thm_result_if.source  result,
	thm_cfg_if.sink       cfg
);

	typedef struct packed {
		logic [thm_pkg::CH_W-1:0]  ch;
		logic                      deg;
	} side_t;

	typedef struct packed {
		logic [thm_pkg::CH_W-1:0]          ch;
		logic signed [thm_pkg::TEMP_W-1:0] temp;
		logic                              fault;
	} out_item_t;

	localparam int unsigned LAST = thm_pkg::PIPE_LAT - 1;

	logic [thm_pkg::BETA_W-1:0]   beta_first_q;
	logic [thm_pkg::BETA_W-1:0]   beta_other_q;
	logic [thm_pkg::OHM_W-1:0]    r0_q;
	logic [thm_pkg::OHM_W-1:0]    series_q;

	logic                         en;
	logic [thm_pkg::ADC_BITS-1:0] code_c;
	logic [thm_pkg::BETA_W-1:0]   beta_c;
	logic                         deg_c;

	logic [thm_pkg::LOG_W-1:0]    ncode_s1;
	logic [thm_pkg::LOG_W-1:0]    nrest_s1;
	logic [thm_pkg::LOG_W-1:0]    nser_s1;
	logic [thm_pkg::LOG_W-1:0]    nr0_s1;
	logic [thm_pkg::BETA_W-1:0]   beta_s1;
	logic                         vld_s [thm_pkg::PIPE_LAT];
	side_t                        side_s [thm_pkg::PIPE_LAT];

	logic [thm_pkg::LN_W-1:0]     ln_code;
	logic [thm_pkg::LN_W-1:0]     ln_rest;
	logic [thm_pkg::LN_W-1:0]     ln_ser;
	logic [thm_pkg::LN_W-1:0]     ln_r0;
	logic [thm_pkg::KB_W-1:0]     kb;
	logic [thm_pkg::BETA_W-1:0]   beta_d;
	thm_pkg::thm_res_t            div_res;

	out_item_t                    item_c;
	logic                         item_v;
	logic                         out_take;
	out_item_t                    out_q;
	logic                         out_v_q;
	out_item_t                    skid_q;
	logic                         skid_v_q;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q <= thm_pkg::BETA_FIRST_RST;
			beta_other_q <= thm_pkg::BETA_OTHER_RST;
			r0_q <= thm_pkg::R0_RST;
			series_q <= thm_pkg::SERIES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				thm_pkg::CFG_BETA_FIRST: beta_first_q <= cfg.data[thm_pkg::BETA_W-1:0];
				thm_pkg::CFG_BETA_OTHER: beta_other_q <= cfg.data[thm_pkg::BETA_W-1:0];
				thm_pkg::CFG_R0:         r0_q <= cfg.data[thm_pkg::OHM_W-1:0];
				thm_pkg::CFG_SERIES:     series_q <= cfg.data[thm_pkg::OHM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline advances unless the skid register is occupied.
	assign en = !skid_v_q;
	assign sample.ready = en;

	// Beta choice and the degenerate cases that bypass the arithmetic.
	assign code_c = sample.adc_code[thm_pkg::ADC_BITS-1:0];
	assign beta_c = (sample.channel < thm_pkg::CH_W'(thm_pkg::FIRST_GROUP))
		? beta_first_q : beta_other_q;
	assign deg_c = (code_c == '0) || (series_q == '0) || (r0_q == '0) || (beta_c == '0)
		|| (32'(sample.channel) >= thm_pkg::CHANNELS);

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			ncode_s1 <= thm_pkg::LOG_W'(code_c);
			nrest_s1 <= thm_pkg::LOG_W'((thm_pkg::ADC_BITS+1)'(thm_pkg::ADC_FULL)
				- (thm_pkg::ADC_BITS+1)'(code_c));
			nser_s1 <= thm_pkg::LOG_W'(series_q);
			nr0_s1 <= thm_pkg::LOG_W'(r0_q);
			beta_s1 <= beta_c;
			side_s[0] <= '{ch: sample.channel, deg: deg_c};
			for (int i = 1; i < thm_pkg::PIPE_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < thm_pkg::PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= sample.valid;
			for (int i = 1; i < thm_pkg::PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Four logarithm lanes and the beta/298.15 term run side by side.
	thm_log_lane u_log_code (.clk(clk), .en(en), .n(ncode_s1), .ln(ln_code));
	thm_log_lane u_log_rest (.clk(clk), .en(en), .n(nrest_s1), .ln(ln_rest));
	thm_log_lane u_log_ser (.clk(clk), .en(en), .n(nser_s1), .ln(ln_ser));
	thm_log_lane u_log_r0 (.clk(clk), .en(en), .n(nr0_s1), .ln(ln_r0));

	thm_cdiv u_cdiv (
		.clk(clk),
		.en(en),
		.beta(beta_s1),
		.kb(kb),
		.beta_out(beta_d)
	);

	thm_div u_div (
		.clk(clk),
		.en(en),
		.ln_code(ln_code),
		.ln_rest(ln_rest),
		.ln_ser(ln_ser),
		.ln_r0(ln_r0),
		.kb(kb),
		.beta(beta_d),
		.res(div_res)
	);

	// Final result of the pipeline.
	assign item_v = vld_s[LAST];
	assign item_c.ch = side_s[LAST].ch;
	assign item_c.temp = side_s[LAST].deg ? thm_pkg::TEMP_FLOOR : div_res.temp;
	assign item_c.fault = side_s[LAST].deg | div_res.fault;

	assign out_take = out_v_q && result.ready;

	// Output and skid occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= en && item_v;
			end
		end else if (en && item_v) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	// Output and skid payload.
	always_ff @(posedge clk) begin
		if (out_take && skid_v_q) begin
			out_q <= skid_q;
		end else if (en && item_v && (out_take || !out_v_q)) begin
			out_q <= item_c;
		end
		if (en && item_v && out_v_q && !out_take) begin
			skid_q <= item_c;
		end
	end

	assign result.valid = out_v_q;
	assign result.channel_out = out_q.ch;
	assign result.temp_centi_c = out_q.temp;
	assign result.fault = out_q.fault;

	`ASSERT_SAME(a_skid_needs_out, skid_v_q, out_v_q, "skid register full while output is empty")
	`ASSERT_NEXT(a_accept_enters, sample.valid && sample.ready, vld_s[0], "accepted request lost at entry")
	`ASSERT_NEXT(a_stall_fills_skid, out_v_q && !result.ready && en && item_v, skid_v_q, "stalled result dropped")
	`ASSERT_SAME(a_clean_in_range, result.valid && !result.fault, $signed(result.temp_centi_c) >= thm_pkg::TEMP_FLOOR, "unflagged result below absolute zero")

endmodule

// ----- tb/thm_temp_scoreboard.sv -----
`timescale 1ns / 1ps

// Expected temperatures for accepted samples, checked in order against results.
class thm_temp_scoreboard;
	typedef struct {
		logic [thm_pkg::CH_W-1:0] channel;
		logic signed [thm_pkg::TEMP_W-1:0] temp;
		logic fault;
	} temp_exp_t;

	temp_exp_t pending_temps[$];
	int unsigned errors;
	int unsigned checked;
	logic [13:0] beta_first;
	logic [13:0] beta_other;
	logic [19:0] r0;
	logic [19:0] series;

	function new();
		errors = 0;
		checked = 0;
		beta_first = 14'd3940;
		beta_other = 14'd3892;
		r0 = 20'd10000;
		series = 20'd19000;
	endfunction

	function void write_reg(thm_pkg::cfg_index_t idx, logic [19:0] value);
		case (idx)
			thm_pkg::CFG_BETA_FIRST: beta_first = value[13:0];
			thm_pkg::CFG_BETA_OTHER: beta_other = value[13:0];
			thm_pkg::CFG_R0: r0 = value;
			thm_pkg::CFG_SERIES: series = value;
		endcase
	endfunction

	// Base-2 logarithm in Q30 by repeated squaring of the mantissa.
	function longint unsigned log2_q30(longint unsigned n);
		longint unsigned msb;
		longint unsigned m;
		longint unsigned res;
		if (n == 0) return 0;
		n = n & 64'hFFFF_FFFF;
		msb = 0;
		while (msb < 31 && (n >> (msb + 1)) != 0) msb++;
		if (msb <= 30) m = n << (30 - msb);
		else m = n >> (msb - 30);
		res = msb << 30;
		for (int i = 29; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				res = res | (64'd1 << i);
			end
		end
		return res;
	endfunction

	function longint ln_q30(longint unsigned n);
		return longint'((log2_q30(n) * 64'd744261118) >> 30);
	endfunction

	// Notes one accepted sample and queues its expected temperature.
	function void note_sample(logic [2:0] ch, logic [11:0] code);
		temp_exp_t e;
		longint unsigned beta;
		longint unsigned num;
		longint unsigned xd;
		longint unsigned tk;
		longint x;
		longint t;
		beta = (ch < 2) ? beta_first : beta_other;
		t = -27315;
		e.fault = 1'b1;
		if (code != 0 && series != 0 && r0 != 0 && beta != 0) begin
			num = (beta * 100) << 30;
			x = ln_q30(code) + ln_q30(series) - ln_q30(4096 - code) - ln_q30(r0)
				+ longint'((num + 29815 / 2) / 29815);
			if (x <= 0) begin
				t = 32767;
			end else begin
				xd = longint'(x);
				tk = (num + xd / 2) / xd;
				if (tk > 32767 + 27315) begin
					t = 32767;
				end else begin
					t = longint'(tk) - 27315;
					e.fault = 1'b0;
				end
			end
		end
		e.channel = ch;
		e.temp = t[15:0];
		pending_temps.push_back(e);
	endfunction

	// Compares one accepted result with the oldest expectation.
	function void check_result(logic [2:0] ch, logic signed [15:0] temp, logic fault);
		temp_exp_t e;
		if (pending_temps.size() == 0) begin
			$display("%0t: unexpected result ch=%0d temp=%0d fault=%0d", $time, ch, temp,
				fault);
			errors++;
			return;
		end
		e = pending_temps.pop_front();
		checked++;
		if (ch !== e.channel || temp !== e.temp || fault !== e.fault) begin
			$display("%0t: expected ch=%0d temp=%0d fault=%0d, got ch=%0d temp=%0d fault=%0d",
				$time, e.channel, e.temp, e.fault, ch, temp, fault);
			errors++;
		end
	endfunction
endclass

// ----- tb/tb_thermistor_adc_to_temperature_core.sv -----
`timescale 1ns / 1ps

module tb_thermistor_adc_to_temperature_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_off = 1'b0;

	thm_sample_if sample ();
	thm_result_if result ();
	thm_cfg_if cfg ();

	thm_temp_scoreboard temps = new();

	thermistor_adc_to_temperature_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always #5 clk = ~clk;

	initial begin
		sample.valid = 1'b0;
		sample.channel = '0;
		sample.adc_code = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = thm_pkg::CFG_BETA_FIRST;
		cfg.data = '0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Writes one register, then leaves the channel idle.
	task automatic write_reg(thm_pkg::cfg_index_t idx, logic [19:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		temps.write_reg(idx, value);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request and waits for it to be taken; gap_on adds idle cycles first.
	task automatic send_sample(logic [2:0] ch, logic [11:0] code, bit gap_on);
		int unsigned g;
		g = gap_on ? gap_len() : 0;
		if (g != 0) begin
			sample.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.channel <= ch;
		sample.adc_code <= code;
		do @(posedge clk); while (!sample.ready);
		temps.note_sample(ch, code);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (temps.pending_temps.size() != 0) @(posedge clk);
		repeat (thm_pkg::PIPE_LAT + 10) @(posedge clk);
	endtask

	// Random codes, weighted toward the ends of the scale.
	function automatic logic [11:0] pick_code();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 12'($urandom_range(0, 8));
		if (r == 1) return 12'($urandom_range(4087, 4095));
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic random_phase(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_sample(3'($urandom_range(0, 7)), pick_code(), ($urandom_range(0, 3) == 0));
		drain();
	endtask

	// Receiver: random stalls, plus a long hold-off when asked.
	initial begin
		int unsigned g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g != 0) begin
				result.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			temps.check_result(result.channel_out, result.temp_centi_c, result.fault);
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ends of the scale, every channel, and the fault cases.
		send_sample(3'd0, 12'd0, 1'b0);
		send_sample(3'd7, 12'd4095, 1'b0);
		send_sample(3'd1, 12'd1, 1'b0);
		send_sample(3'd2, 12'd2048, 1'b0);
		for (int c = 0; c < 8; c++) send_sample(c[2:0], 12'd2600, 1'b0);
		send_sample(3'd5, 12'hAAA, 1'b0);
		send_sample(3'd2, 12'h555, 1'b0);
		drain();

		// Zero registers force the floor with a fault.
		write_reg(thm_pkg::CFG_BETA_FIRST, 20'd0);
		write_reg(thm_pkg::CFG_R0, 20'd0);
		send_sample(3'd0, 12'd1000, 1'b0);
		send_sample(3'd4, 12'd1000, 1'b0);
		drain();
		write_reg(thm_pkg::CFG_R0, 20'd10000);
		write_reg(thm_pkg::CFG_SERIES, 20'd0);
		send_sample(3'd3, 12'd1000, 1'b0);
		drain();
		write_reg(thm_pkg::CFG_BETA_OTHER, 20'd0);
		write_reg(thm_pkg::CFG_SERIES, 20'd19000);
		write_reg(thm_pkg::CFG_BETA_FIRST, 20'd3940);
		send_sample(3'd6, 12'd1000, 1'b0);
		send_sample(3'd1, 12'd1000, 1'b0);
		drain();

		// Reset values, with one long receiver hold-off while the sender keeps going.
		write_reg(thm_pkg::CFG_BETA_OTHER, 20'd3892);
		hold_off = 1'b1;
		random_phase(500);

		// Extremes: small first-group beta, large other beta, tiny r0, huge series; then the opposite corner.
		write_reg(thm_pkg::CFG_BETA_FIRST, 20'd1000);
		write_reg(thm_pkg::CFG_BETA_OTHER, 20'd10000);
		write_reg(thm_pkg::CFG_R0, 20'd100);
		write_reg(thm_pkg::CFG_SERIES, 20'd1000000);
		random_phase(400);
		write_reg(thm_pkg::CFG_BETA_FIRST, 20'd16383);
		write_reg(thm_pkg::CFG_BETA_OTHER, 20'd1000);
		write_reg(thm_pkg::CFG_R0, 20'hFFFFF);
		write_reg(thm_pkg::CFG_SERIES, 20'd100);
		random_phase(400);

		// Random in-range settings.
		for (int p = 0; p < 4; p++) begin
			write_reg(thm_pkg::CFG_BETA_FIRST, 20'($urandom_range(1000, 10000)));
			write_reg(thm_pkg::CFG_BETA_OTHER, 20'($urandom_range(1000, 10000)));
			write_reg(thm_pkg::CFG_R0, 20'($urandom_range(100, 1000000)));
			write_reg(thm_pkg::CFG_SERIES, 20'($urandom_range(100, 1000000)));
			random_phase(180);
		end

		$display("Checked %0d temperatures across reset, extreme and random register settings.",
			temps.checked);
		if (temps.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/thm_pkg.sv
hdl/thm_ifs.sv
hdl/thm_log_lane.sv
hdl/thm_cdiv.sv
hdl/thm_div.sv
hdl/thermistor_adc_to_temperature_core.sv
tb/thm_temp_scoreboard.sv
tb/tb_thermistor_adc_to_temperature_core.sv
